// ===== rtl/core/vsk_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsk_pkg
// Shared types and constants of the video sync, interrupt and keyboard core.
// ----------------------------------------------------------------------------
package vsk_pkg;

  localparam int LINE_PERIOD_DEF = 207;
  localparam int CNT_W           = 8;
  localparam int ROWS            = 8;

  localparam logic [CNT_W-1:0] HSYNC_FIRST = 8'd16;
  localparam logic [CNT_W-1:0] HSYNC_END   = 8'd32;
  localparam logic [7:0]       KEY_MASK    = 8'h7f;
  localparam logic [7:0]       TAPE_BIT    = 8'h80;
  localparam logic [7:0]       BUS_FREE    = 8'hff;

  localparam logic [0:0] REG_MODE = 1'b0;

  typedef enum logic [3:0] {
    FN_CLOCK      = 4'd0,
    FN_M1         = 4'd1,
    FN_INTACK     = 4'd2,
    FN_REFR_START = 4'd3,
    FN_REFR_END   = 4'd4,
    FN_IORD_START = 4'd5,
    FN_IORD_END   = 4'd6,
    FN_IOWR       = 4'd7,
    FN_CHAR_START = 4'd8,
    FN_CHAR_END   = 4'd9,
    FN_KEYROW     = 4'd10
  } func_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] address;
    logic [7:0]  data;
    logic        halt_n;
    logic        tape_low;
    logic [2:0]  key_row;
    logic [7:0]  key_bits;
  } item_t;

  typedef struct packed {
    logic       sync_active;
    logic       int_n;
    logic       nmi_n;
    logic       wait_n;
    logic [7:0] data_out;
    logic       video_valid;
    logic [7:0] video_byte;
    logic       rom_substitute;
    logic [8:0] rom_low_address;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]      hsync_count;
    logic                  hsync_on;
    logic                  hsync_prev;
    logic                  vsync_on;
    logic [2:0]            char_line;
    logic                  nmi_gen_on;
    logic                  fetch_pending;
    logic                  invert_video;
    logic [8:0]            char_address;
    logic [ROWS-1:0][7:0]  key_rows;
    logic                  int_level;
    logic                  nmi_level;
    logic                  wait_level;
    logic [7:0]            data_drive;
  } state_t;

  localparam state_t STATE_RESET = '{
    hsync_count:   '0,
    hsync_on:      1'b0,
    hsync_prev:    1'b0,
    vsync_on:      1'b0,
    char_line:     3'd0,
    nmi_gen_on:    1'b0,
    fetch_pending: 1'b0,
    invert_video:  1'b0,
    char_address:  9'd0,
    key_rows:      '1,
    int_level:     1'b1,
    nmi_level:     1'b1,
    wait_level:    1'b1,
    data_drive:    8'hff
  };

endpackage

// ===== rtl/core/vsk_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsk_cfg
// APB register file holding the model mode bit.
// ----------------------------------------------------------------------------
module vsk_cfg (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready,
  output logic        mode
);

  logic mode_r;
  logic mode_nxt;
  logic hit;

  assign hit        = (cfg_paddr[2:2] == vsk_pkg::REG_MODE);
  assign cfg_pready = 1'b1;
  assign mode       = mode_r;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && hit) begin
      mode_nxt = cfg_pwdata[0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (hit) begin
      cfg_prdata = {31'd0, mode_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else begin
      mode_r <= mode_nxt;
    end
  end

endmodule

// ===== rtl/core/vsk_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsk_step
// Next-state and result logic for one bus event.
// ----------------------------------------------------------------------------
module vsk_step #(
  parameter int LINE_PERIOD = vsk_pkg::LINE_PERIOD_DEF
) (
  input  logic            mode,
  input  vsk_pkg::item_t  item,
  input  vsk_pkg::state_t st,
  output vsk_pkg::state_t st_nxt,
  output vsk_pkg::result_t res
);

  always_comb begin
    vsk_pkg::state_t  s;
    logic [8:0]       cnt_inc;
    logic [7:0]       rd;
    logic             vvalid;
    logic [7:0]       vbyte;
    s       = st;
    vvalid  = 1'b0;
    vbyte   = 8'h00;
    cnt_inc = {1'b0, st.hsync_count} + 9'd1;
    rd      = vsk_pkg::KEY_MASK;

    case (item.func)
      vsk_pkg::FN_CLOCK: begin
        if (mode) begin
          if (cnt_inc >= 9'(LINE_PERIOD)) begin
            s.hsync_count = '0;
          end else begin
            s.hsync_count = cnt_inc[vsk_pkg::CNT_W-1:0];
          end
          if (s.hsync_count >= vsk_pkg::HSYNC_FIRST && s.hsync_count < vsk_pkg::HSYNC_END) begin
            s.hsync_on = 1'b1;
            if (!s.hsync_prev) begin
              s.char_line = s.char_line + 3'd1;
            end
            s.hsync_prev = 1'b1;
          end else begin
            s.hsync_on   = 1'b0;
            s.hsync_prev = 1'b0;
          end
          if (s.nmi_gen_on && s.hsync_on) begin
            s.nmi_level  = 1'b0;
            s.wait_level = !item.halt_n;
          end else begin
            s.nmi_level  = 1'b1;
            s.wait_level = 1'b1;
          end
        end
      end
      vsk_pkg::FN_M1: begin
        if (!mode && st.hsync_count < 8'd4) begin
          if (st.hsync_count == 8'd1) begin
            s.hsync_on = 1'b1;
            if (!s.hsync_prev) begin
              s.char_line = s.char_line + 3'd1;
            end
            s.hsync_prev = 1'b1;
          end
          if (st.hsync_count == 8'd3) begin
            s.hsync_on   = 1'b0;
            s.hsync_prev = 1'b0;
          end
          s.hsync_count = cnt_inc[vsk_pkg::CNT_W-1:0];
        end
      end
      vsk_pkg::FN_INTACK: begin
        s.hsync_count = '0;
      end
      vsk_pkg::FN_REFR_START: begin
        s.int_level = item.address[6];
      end
      vsk_pkg::FN_REFR_END: begin
        s.int_level = 1'b1;
        if (st.fetch_pending) begin
          s.fetch_pending = 1'b0;
          vvalid          = 1'b1;
          vbyte           = item.data ^ {8{st.invert_video}};
        end
      end
      vsk_pkg::FN_IORD_START: begin
        if (item.address[2:0] == 3'b110) begin
          if (!st.nmi_gen_on) begin
            s.vsync_on = 1'b1;
          end
          for (int r = 0; r < vsk_pkg::ROWS; r++) begin
            if (!item.address[8+r]) begin
              rd = rd & st.key_rows[r];
            end
          end
          if (item.tape_low) begin
            rd = rd | vsk_pkg::TAPE_BIT;
          end
          s.data_drive = rd;
        end
      end
      vsk_pkg::FN_IORD_END: begin
        s.data_drive = vsk_pkg::BUS_FREE;
      end
      vsk_pkg::FN_IOWR: begin
        if (!item.address[0]) begin
          s.nmi_gen_on = mode;
        end
        if (!item.address[1]) begin
          s.nmi_gen_on = 1'b0;
        end
        if (item.address[2:0] == 3'b111 && !s.nmi_gen_on) begin
          s.char_line = 3'd0;
          s.vsync_on  = 1'b0;
        end
      end
      vsk_pkg::FN_CHAR_START: begin
        if (!item.data[6] && item.address[15] && item.halt_n) begin
          s.char_address  = {item.data[5:0], st.char_line};
          s.fetch_pending = 1'b1;
          s.invert_video  = !item.data[7];
          s.data_drive    = 8'h00;
        end else begin
          s.data_drive = vsk_pkg::BUS_FREE;
        end
      end
      vsk_pkg::FN_CHAR_END: begin
        s.data_drive = vsk_pkg::BUS_FREE;
      end
      vsk_pkg::FN_KEYROW: begin
        s.key_rows[item.key_row] = item.key_bits;
      end
      default: begin
      end
    endcase

    st_nxt                = s;
    res.sync_active       = s.hsync_on | s.vsync_on;
    res.int_n             = s.int_level;
    res.nmi_n             = s.nmi_level;
    res.wait_n            = s.wait_level;
    res.data_out          = s.data_drive;
    res.video_valid       = vvalid;
    res.video_byte        = vbyte;
    res.rom_substitute    = s.fetch_pending;
    res.rom_low_address   = s.fetch_pending ? s.char_address : 9'd0;
  end

endmodule

// ===== rtl/core/video_sync_keyboard_ula_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_sync_keyboard_ula_core
// Sync generator, interrupt lines, keyboard rows and character fetch.
// ----------------------------------------------------------------------------
// usage
//   in_*  : one bus event per word; in_tuser carries the event code, in_tdata
//           the bus and keyboard fields
//   out_* : one result word per event: line levels, data drive, video byte,
//           rom low address; out_tuser flags a valid video byte
//   cfg_* : apb port, register at byte 0 holds the model mode bit
// pipeline
//   input register, then result register; the state is updated as the
//   result is loaded
// throughput
//   one word per cycle while out_tready stays high, set by the state update loop
// reset
//   rst_n low clears both stages and loads the power-up state, mode = 1
// stall
//   a held result keeps its word; one more input word is buffered, then
//   in_tready drops until out_tready returns
// ----------------------------------------------------------------------------
module video_sync_keyboard_ula_core #(
  parameter int LINE_PERIOD = vsk_pkg::LINE_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // address[15:0] data[23:16] halt_n[24] tape_low[25] key_row[28:26]
  // key_bits[36:29] zero[39:37]
  input  logic [39:0] in_tdata,
  // func[3:0]
  input  logic [3:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // sync_active[0] int_n[1] nmi_n[2] wait_n[3] data_out[11:4]
  // video_byte[19:12] rom_substitute[20] rom_low_address[29:21] zero[31:30]
  output logic [31:0] out_tdata,
  // video_valid[0]
  output logic        out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             mode;
  logic             in_valid_r;
  vsk_pkg::item_t   in_item_r;
  vsk_pkg::item_t   in_item;
  logic             out_valid_r;
  vsk_pkg::result_t out_res_r;
  vsk_pkg::result_t res_nxt;
  vsk_pkg::state_t  state_r;
  vsk_pkg::state_t  state_nxt;
  logic             adv;

  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  assign in_item.func     = in_tuser;
  assign in_item.address  = in_tdata[15:0];
  assign in_item.data     = in_tdata[23:16];
  assign in_item.halt_n   = in_tdata[24];
  assign in_item.tape_low = in_tdata[25];
  assign in_item.key_row  = in_tdata[28:26];
  assign in_item.key_bits = in_tdata[36:29];

  vsk_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .mode        (mode)
  );

  vsk_step #(
    .LINE_PERIOD (LINE_PERIOD)
  ) u_step (
    .mode   (mode),
    .item   (in_item_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= vsk_pkg::STATE_RESET;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= in_item;
    end
    if (adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.video_valid;
  assign out_tdata  = {2'b00,
                       out_res_r.rom_low_address,
                       out_res_r.rom_substitute,
                       out_res_r.video_byte,
                       out_res_r.data_out,
                       out_res_r.wait_n,
                       out_res_r.nmi_n,
                       out_res_r.int_n,
                       out_res_r.sync_active};

endmodule

// ===== rtl/core/vsk_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vsk_checker
// Port-level checks of the core, bound to the top level.
// ----------------------------------------------------------------------------
module vsk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_video_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[19:12] == 8'h00)
    else $error("video byte without video valid");

  a_rom_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[20] |-> out_tdata[29:21] == 9'd0)
    else $error("rom address without substitute");

  a_wait_nmi: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[3])
    else $error("wait asserted without nmi");

endmodule

bind video_sync_keyboard_ula_core vsk_checker u_vsk_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb_video_sync_keyboard_ula_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_video_sync_keyboard_ula_core
// Self-checking bench for the sync, interrupt, keyboard and character fetch
// core. Bus events go in on the input stream and a tracker class works out
// the expected line levels, data drive and video byte of each event. Every
// result word is compared field by field in order. Both stream sides stall
// at random. The model mode is switched between phases while the core is
// idle.
// ----------------------------------------------------------------------------
module tb_video_sync_keyboard_ula_core;

  localparam int LINE_PERIOD = vsk_pkg::LINE_PERIOD_DEF;
  localparam logic [2:0] MODE_ADDR = {vsk_pkg::REG_MODE, 2'b00};

  class ula_result_tracker;
    bit         later_mode;
    logic [7:0] hcount;
    bit         hs_on, hs_prev, vs_on;
    logic [2:0] line;
    bit         nmi_gen, fetch_pend, invert;
    logic [8:0] char_addr;
    logic [7:0] rows [8];
    bit         int_lvl, nmi_lvl, wait_lvl;
    logic [7:0] drive;
    vsk_pkg::result_t pending_words [$];
    int         errors;

    function new();
      later_mode = 1'b1;
      hcount = '0;
      hs_on = 1'b0; hs_prev = 1'b0; vs_on = 1'b0;
      line = '0;
      nmi_gen = 1'b0; fetch_pend = 1'b0; invert = 1'b0;
      char_addr = '0;
      foreach (rows[i]) rows[i] = 8'hff;
      int_lvl = 1'b1; nmi_lvl = 1'b1; wait_lvl = 1'b1;
      drive = vsk_pkg::BUS_FREE;
      errors = 0;
    endfunction

    function void raise_hsync();
      hs_on = 1'b1;
      if (!hs_prev) line = line + 3'd1;
      hs_prev = 1'b1;
    endfunction

    function void drop_hsync();
      hs_on = 1'b0;
      hs_prev = 1'b0;
    endfunction

    function int outstanding();
      return pending_words.size();
    endfunction

    function void note_event(vsk_pkg::item_t it);
      int               nxt;
      logic [7:0]       key_val;
      vsk_pkg::result_t w;
      w.video_valid = 1'b0;
      w.video_byte  = 8'h00;
      case (it.func)
        vsk_pkg::FN_CLOCK: begin
          if (later_mode) begin
            nxt = int'(hcount) + 1;
            if (nxt >= LINE_PERIOD) nxt = 0;
            hcount = 8'(nxt);
            if (hcount >= vsk_pkg::HSYNC_FIRST && hcount < vsk_pkg::HSYNC_END) raise_hsync();
            else drop_hsync();
            if (nmi_gen && hs_on) begin
              nmi_lvl  = 1'b0;
              wait_lvl = ~it.halt_n;
            end else begin
              nmi_lvl  = 1'b1;
              wait_lvl = 1'b1;
            end
          end
        end
        vsk_pkg::FN_M1: begin
          if (!later_mode && hcount < 8'd4) begin
            if (hcount == 8'd1) raise_hsync();
            if (hcount == 8'd3) drop_hsync();
            hcount = hcount + 8'd1;
          end
        end
        vsk_pkg::FN_INTACK: hcount = '0;
        vsk_pkg::FN_REFR_START: int_lvl = it.address[6];
        vsk_pkg::FN_REFR_END: begin
          int_lvl = 1'b1;
          if (fetch_pend) begin
            fetch_pend    = 1'b0;
            w.video_valid = 1'b1;
            w.video_byte  = invert ? ~it.data : it.data;
          end
        end
        vsk_pkg::FN_IORD_START: begin
          if (it.address[2:0] == 3'b110) begin
            key_val = vsk_pkg::KEY_MASK;
            if (!nmi_gen) vs_on = 1'b1;
            for (int r = 0; r < 8; r++)
              if (!it.address[8+r]) key_val &= rows[r];
            if (it.tape_low) key_val |= vsk_pkg::TAPE_BIT;
            drive = key_val;
          end
        end
        vsk_pkg::FN_IORD_END, vsk_pkg::FN_CHAR_END: drive = vsk_pkg::BUS_FREE;
        vsk_pkg::FN_IOWR: begin
          if (!it.address[0]) nmi_gen = later_mode;
          if (!it.address[1]) nmi_gen = 1'b0;
          if (it.address[2:0] == 3'b111 && !nmi_gen) begin
            line  = '0;
            vs_on = 1'b0;
          end
        end
        vsk_pkg::FN_CHAR_START: begin
          if (!it.data[6] && it.address[15] && it.halt_n) begin
            char_addr  = {it.data[5:0], line};
            fetch_pend = 1'b1;
            invert     = !it.data[7];
            drive      = 8'h00;
          end else begin
            drive = vsk_pkg::BUS_FREE;
          end
        end
        vsk_pkg::FN_KEYROW: rows[it.key_row] = it.key_bits;
        default: ;
      endcase
      w.sync_active     = hs_on | vs_on;
      w.int_n           = int_lvl;
      w.nmi_n           = nmi_lvl;
      w.wait_n          = wait_lvl;
      w.data_out        = drive;
      w.rom_substitute  = fetch_pend;
      w.rom_low_address = fetch_pend ? char_addr : 9'd0;
      pending_words.push_back(w);
    endfunction

    function void field_cmp(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_word(logic [31:0] d, logic u);
      vsk_pkg::result_t w;
      if (pending_words.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result word, expected none actual %h/%b",
                 $time, d, u);
        return;
      end
      w = pending_words.pop_front();
      field_cmp("sync_active", w.sync_active, d[0]);
      field_cmp("int_n", w.int_n, d[1]);
      field_cmp("nmi_n", w.nmi_n, d[2]);
      field_cmp("wait_n", w.wait_n, d[3]);
      field_cmp("data_out", w.data_out, d[11:4]);
      field_cmp("video_valid", w.video_valid, u);
      field_cmp("video_byte", w.video_byte, d[19:12]);
      field_cmp("rom_substitute", w.rom_substitute, d[20]);
      field_cmp("rom_low_address", w.rom_low_address, d[29:21]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic [3:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ula_result_tracker tracker = new();
  bit later_mode = 1'b1;
  bit quiet_tail = 1'b0;

  video_sync_keyboard_ula_core #(
    .LINE_PERIOD(LINE_PERIOD)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side back-pressure
  initial begin
    int stall_len;
    out_tready = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_len = $urandom_range(1, 8);
        out_tready <= 1'b0;
        repeat (stall_len) @(negedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_word(out_tdata, out_tuser);
  end

  function automatic vsk_pkg::item_t mk_item(logic [3:0] fn, logic [15:0] addr,
                                             logic [7:0] dat, logic hn, logic tl,
                                             logic [2:0] row, logic [7:0] bits);
    vsk_pkg::item_t it;
    it.func = fn; it.address = addr; it.data = dat; it.halt_n = hn;
    it.tape_low = tl; it.key_row = row; it.key_bits = bits;
    return it;
  endfunction

  function automatic vsk_pkg::item_t rand_item(logic [3:0] fn);
    return mk_item(fn, 16'($urandom), 8'($urandom), $urandom_range(0, 7) != 0,
                   1'($urandom), 3'($urandom), 8'($urandom));
  endfunction

  task automatic hold_input(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic send_word(vsk_pkg::item_t it);
    if (!quiet_tail && $urandom_range(0, 7) == 0) hold_input($urandom_range(1, 8));
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, it.key_bits, it.key_row, it.tape_low, it.halt_n,
                  it.data, it.address};
    in_tuser  <= it.func;
    do @(posedge clk); while (!in_tready);
    tracker.note_event(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    drain_results();
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= MODE_ADDR;
    cfg_pwdata  <= {31'd0, m};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    tracker.later_mode = m;
    later_mode = m;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic run_directed();
    send_word(mk_item(vsk_pkg::FN_KEYROW, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_KEYROW, 16'hffff, 8'hff, 1'b1, 1'b1, 3'd7, 8'haa));
    send_word(mk_item(vsk_pkg::FN_KEYROW, 16'h1234, 8'h5a, 1'b1, 1'b0, 3'd3, 8'hff));
    send_word(mk_item(vsk_pkg::FN_IORD_START, 16'hfefe, 8'h00, 1'b1, 1'b1, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_IORD_END, 16'hfefe, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_IORD_START, 16'h0006, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_IORD_START, 16'hffff, 8'h00, 1'b1, 1'b1, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_IOWR, 16'hfffe, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_CLOCK, 16'h0000, 8'h00, 1'b0, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_IOWR, 16'hfffd, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_IOWR, 16'h0007, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_CHAR_START, 16'h8000, 8'h3f, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_CHAR_END, 16'h8000, 8'h3f, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_REFR_START, 16'h0040, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_REFR_START, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_REFR_END, 16'h0000, 8'ha5, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_CHAR_START, 16'hffff, 8'hc0, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_CHAR_START, 16'h7fff, 8'h80, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_CHAR_START, 16'h8000, 8'hbf, 1'b0, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_CHAR_START, 16'h8000, 8'hbf, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_REFR_END, 16'h0000, 8'hff, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_M1, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    send_word(mk_item(vsk_pkg::FN_INTACK, 16'h0000, 8'h00, 1'b1, 1'b0, 3'd0, 8'h00));
    for (int f = 11; f <= 15; f++)
      send_word(mk_item(4'(f), 16'hffff, 8'hff, 1'b1, 1'b1, 3'd7, 8'hff));
  endtask

  task automatic run_phase(int n_items, bit pause_midway);
    int             sent;
    int             pick;
    int             burst;
    vsk_pkg::item_t it;
    sent = 0;
    while (sent < n_items) begin
      if (pause_midway && sent >= n_items / 2) begin
        drain_results();
        pause_midway = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_word(rand_item(later_mode ? vsk_pkg::FN_CLOCK : vsk_pkg::FN_M1));
        sent++;
      end else if (pick < 42) begin
        burst = $urandom_range(40, 250);
        repeat (burst) send_word(rand_item(vsk_pkg::FN_CLOCK));
        sent += burst;
      end else if (pick < 57) begin
        // opcode fetch with a character fetch and refresh
        send_word(rand_item(vsk_pkg::FN_M1));
        it = rand_item(vsk_pkg::FN_CHAR_START);
        if ($urandom_range(0, 4) != 0) begin
          it.data[6] = 1'b0;
          it.address[15] = 1'b1;
          it.halt_n = 1'b1;
        end
        send_word(it);
        send_word(rand_item(vsk_pkg::FN_CHAR_END));
        send_word(rand_item(vsk_pkg::FN_REFR_START));
        send_word(rand_item(vsk_pkg::FN_REFR_END));
        sent += 5;
      end else if (pick < 67) begin
        it = rand_item(vsk_pkg::FN_IORD_START);
        if ($urandom_range(0, 6) != 0) it.address[2:0] = 3'b110;
        send_word(it);
        send_word(rand_item(vsk_pkg::FN_IORD_END));
        sent += 2;
      end else if (pick < 75) begin
        send_word(rand_item(vsk_pkg::FN_IOWR));
        sent++;
      end else if (pick < 82) begin
        send_word(rand_item(vsk_pkg::FN_KEYROW));
        sent++;
      end else if (pick < (later_mode ? 84 : 92)) begin
        send_word(rand_item(vsk_pkg::FN_INTACK));
        sent++;
      end else if (pick < 95) begin
        send_word(rand_item($urandom_range(0, 1) ? vsk_pkg::FN_REFR_START
                                                 : vsk_pkg::FN_REFR_END));
        sent++;
      end else begin
        send_word(rand_item(4'($urandom_range(0, 15))));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_phase(300, 1'b0);
    write_mode(1'b0);
    run_phase(300, 1'b0);
    write_mode(1'b1);
    run_phase(300, 1'b1);
    write_mode(1'b0);
    run_phase(200, 1'b0);
    write_mode(1'b1);
    quiet_tail = 1'b1;
    run_phase(300, 1'b0);

    drain_results();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
